@@ hdl/vertex_dedup_indexer_unit_macros.svh @@
// Assertion macros used by the port-level checker.
`ifndef VERTEX_DEDUP_INDEXER_UNIT_MACROS_SVH
`define VERTEX_DEDUP_INDEXER_UNIT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define VDI_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication outside reset.
`define VDI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

@@ hdl/vdi_pkg.sv @@
// Shared constants and types for the vertex dedup indexer.
package vdi_pkg;
    localparam int unsigned TableDepth = 1024;
    localparam int unsigned FracBits   = 16;
    localparam int unsigned IdxW       = $clog2(TableDepth);
    localparam int unsigned CntW       = IdxW + 1;
    localparam int unsigned TolW       = 17;
    localparam int unsigned CfgW       = 17;
    localparam int unsigned CfgIdxW    = 1;

    localparam logic [CfgIdxW-1:0] REG_CAPACITY  = 1'd0;
    localparam logic [CfgIdxW-1:0] REG_TOLERANCE = 1'd1;

    localparam logic [1:0] OUT_MATCHED  = 2'd0;
    localparam logic [1:0] OUT_APPENDED = 2'd1;
    localparam logic [1:0] OUT_DROPPED  = 2'd2;

    typedef logic [31:0] t_word;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;        // capture input transaction
        logic sq_step;     // accumulate one square (component index in sq_sel)
        logic [1:0] sq_sel;
        logic sqrt_init;
        logic sqrt_step;
        logic div_init;    // start divide of component div_sel
        logic div_step;
        logic [1:0] div_sel;
        logic div_store;   // write quotient back as normalized component
        logic rd_issue;    // issue read of entry r_scan
        logic scan_clr;
        logic cmp_chk;     // compare registered read data
        logic commit;      // form result, update counts, write if appending
    } t_cmd;

    typedef struct packed {
        logic scan_done;   // all stored entries issued
        logic found;
        logic sqrt_done;
        logic div_done;
    } t_sts;
endpackage

@@ hdl/vdi_ram.sv @@
// Generic single-port write, single-port registered-read RAM.
module vdi_ram #(
    parameter int unsigned Width = 32,
    parameter int unsigned Depth = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

@@ hdl/vdi_ctrl.sv @@
// Sequencer: normalize, scan the table, then deliver one result.
module vdi_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    output logic           o_valid,
    input  logic           i_stall,
    input  vdi_pkg::t_sts  i_sts,
    output vdi_pkg::t_cmd  o_cmd
);
    import vdi_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SQ    = 4'd1;
    localparam logic [3:0] S_SQRT  = 4'd2;
    localparam logic [3:0] S_DIVI  = 4'd3;
    localparam logic [3:0] S_DIV   = 4'd4;
    localparam logic [3:0] S_SCAN  = 4'd5;
    localparam logic [3:0] S_DRAIN = 4'd6;
    localparam logic [3:0] S_COMM  = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    logic [3:0] r_state, n_state;
    logic [1:0] r_sel, n_sel;
    logic       r_chk, n_chk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sel   <= '0;
            r_chk   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
            r_chk   <= n_chk;
        end
    end

    always_comb begin
        n_state = r_state;
        n_sel   = r_sel;
        n_chk   = 1'b0;
        o_cmd   = '0;
        o_cmd.sq_sel  = r_sel;
        o_cmd.div_sel = r_sel;
        o_cmd.cmp_chk = r_chk;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_sel = '0;
                    n_state = S_SQ;
                end
            end
            S_SQ: begin
                o_cmd.sq_step = 1'b1;
                if (r_sel == 2'd2) begin
                    n_sel = '0;
                    n_state = S_SQRT;
                end else begin
                    n_sel = r_sel + 2'd1;
                end
            end
            S_SQRT: begin
                // wait, counting in r_sel, while the last square passes through r_mag and r_prod into the sum
                if (r_sel == 2'd2) begin
                    o_cmd.sqrt_init = 1'b1;
                    n_sel = 2'd3;
                end else if (r_sel == 2'd3) begin
                    if (i_sts.sqrt_done) begin
                        n_sel = '0;
                        n_state = S_DIVI;
                    end else begin
                        o_cmd.sqrt_step = 1'b1;
                    end
                end else begin
                    n_sel = r_sel + 2'd1;
                end
            end
            S_DIVI: begin
                o_cmd.div_init = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    o_cmd.div_store = 1'b1;
                    if (r_sel == 2'd2) begin
                        o_cmd.scan_clr = 1'b1;
                        n_state = S_SCAN;
                    end else begin
                        n_sel = r_sel + 2'd1;
                        n_state = S_DIVI;
                    end
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_SCAN: begin
                // issue one read a cycle; stop on the first registered match
                if (r_chk && i_sts.found) begin
                    n_state = S_COMM;
                end else if (i_sts.scan_done) begin
                    n_state = S_DRAIN;
                end else begin
                    o_cmd.rd_issue = 1'b1;
                    n_chk = 1'b1;
                end
            end
            S_DRAIN: begin
                n_state = S_COMM;
            end
            S_COMM: begin
                o_cmd.commit = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);
endmodule

@@ hdl/vdi_dp.sv @@
// Datapath: normal unit (squares, bitwise sqrt, restoring divide), table scan, counts.
module vdi_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  vdi_pkg::t_cmd                i_cmd,
    output vdi_pkg::t_sts                o_sts,
    input  logic                         i_cfg_we,
    input  logic [vdi_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [vdi_pkg::CfgW-1:0]     i_cfg_data,
    input  logic                         i_new_mesh,
    input  logic [31:0]                  i_pos_x,
    input  logic [31:0]                  i_pos_y,
    input  logic [31:0]                  i_pos_z,
    input  logic [31:0]                  i_norm_x,
    input  logic [31:0]                  i_norm_y,
    input  logic [31:0]                  i_norm_z,
    input  logic [31:0]                  i_tex_u,
    input  logic [31:0]                  i_tex_v,
    output logic [vdi_pkg::IdxW-1:0]     o_vertex_index,
    output logic [1:0]                   o_outcome,
    output logic [vdi_pkg::CntW-1:0]     o_unique_count,
    output logic [vdi_pkg::CntW-1:0]     o_index_count
);
    import vdi_pkg::*;

    localparam int unsigned SqrtSteps = 32;
    localparam int unsigned QW = 49;   // quotient bits: 32 magnitude + FracBits + 1

    logic [CntW-1:0] r_cap, r_vcnt, r_ecnt;
    logic [TolW-1:0] r_tol;
    t_word r_v [8];
    logic [2:0] r_neg;
    logic [65:0] r_sum;
    logic [31:0] r_mag;
    logic        r_mag_v;
    logic [63:0] r_prod;
    logic        r_prod_v;
    // sqrt
    logic [65:0] r_rem;
    logic [32:0] r_root;
    logic [5:0]  r_sqcnt;
    // divide
    logic [QW-1:0] r_dividend;
    logic [33:0]   r_drem;
    logic [QW-1:0] r_quot;
    logic [5:0]    r_dcnt;
    // scan
    logic [CntW-1:0] r_scan;
    logic [IdxW-1:0] r_ridx;
    logic            r_found;
    logic [IdxW-1:0] r_hit;
    logic [IdxW-1:0] r_oidx;
    logic [1:0]      r_oout;

    t_word rd [8];
    logic [CntW-1:0] limit;
    logic [31:0] sel_n;

    assign limit = (r_cap > CntW'(TableDepth)) ? CntW'(TableDepth) : r_cap;

    always_comb begin
        case (i_cmd.sq_sel)
            2'd0: sel_n = r_v[3];
            2'd1: sel_n = r_v[4];
            default: sel_n = r_v[5];
        endcase
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CntW'(TableDepth);
            r_tol <= TolW'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_CAPACITY:  r_cap <= i_cfg_data[CntW-1:0];
                REG_TOLERANCE: r_tol <= i_cfg_data[TolW-1:0];
                default: ;
            endcase
        end
    end

    // normalization arithmetic: magnitude, then square, then accumulate, one stage each
    logic [65:0] sq_next;
    logic [QW-1:0] dnext_div;
    logic [33:0]   dshift;
    logic [33:0]   dsub;
    always_comb begin
        sq_next = r_sum + {2'b0, r_prod};
        dshift = {r_drem[32:0], r_dividend[QW-1]};
        dsub   = dshift - {1'b0, r_root};
        dnext_div = {r_dividend[QW-2:0], 1'b0};
    end

    // sqrt: one result bit per cycle, two radicand bits per step
    logic [65:0] rem_sh;
    logic [65:0] tr;
    logic [65:0] radic;
    assign radic = r_sum;
    always_comb begin
        rem_sh = {r_rem[63:0], radic[6'(2*r_sqcnt+1)], radic[6'(2*r_sqcnt)]};
        tr     = {32'd0, r_root[31:0], 2'b01};
    end

    always_ff @(posedge i_clk) begin
        r_mag_v  <= 1'b0;
        r_prod_v <= 1'b0;
        if (i_cmd.load) begin
            r_v[0] <= i_pos_x; r_v[1] <= i_pos_y; r_v[2] <= i_pos_z;
            r_v[3] <= i_norm_x; r_v[4] <= i_norm_y; r_v[5] <= i_norm_z;
            r_v[6] <= i_tex_u; r_v[7] <= i_tex_v;
            r_neg <= {i_norm_z[31], i_norm_y[31], i_norm_x[31]};
            r_sum <= '0;
        end
        if (i_cmd.sq_step) begin
            r_mag   <= sel_n[31] ? (32'd0 - sel_n) : sel_n;
            r_mag_v <= 1'b1;
        end
        if (r_mag_v) begin
            r_prod   <= r_mag * r_mag;
            r_prod_v <= 1'b1;
        end
        if (r_prod_v) begin
            r_sum <= sq_next;
        end
        if (i_cmd.sqrt_init) begin
            r_rem   <= '0;
            r_root  <= '0;
            r_sqcnt <= 6'(SqrtSteps - 1);
        end
        if (i_cmd.sqrt_step) begin
            if (rem_sh >= tr) begin
                r_rem  <= rem_sh - tr;
                r_root <= {r_root[31:0], 1'b1};
            end else begin
                r_rem  <= rem_sh;
                r_root <= {r_root[31:0], 1'b0};
            end
            r_sqcnt <= r_sqcnt - 6'd1;
        end
        if (i_cmd.div_init) begin
            r_dividend <= {1'b0, (sel_n[31] ? (32'd0 - sel_n) : sel_n), FracBits'(0)};
            r_drem <= '0;
            r_quot <= '0;
            r_dcnt <= 6'(QW);
        end
        if (i_cmd.div_step) begin
            r_dividend <= dnext_div;
            if (!dsub[33]) begin
                r_drem <= dsub;
                r_quot <= {r_quot[QW-2:0], 1'b1};
            end else begin
                r_drem <= dshift;
                r_quot <= {r_quot[QW-2:0], 1'b0};
            end
            r_dcnt <= r_dcnt - 6'd1;
        end
        if (i_cmd.div_store) begin
            if (r_root == '0) begin
                r_v[3'd3 + {1'b0, i_cmd.div_sel}] <= '0;
            end else if (r_neg[i_cmd.div_sel]) begin
                r_v[3'd3 + {1'b0, i_cmd.div_sel}] <= 32'd0 - r_quot[31:0];
            end else begin
                r_v[3'd3 + {1'b0, i_cmd.div_sel}] <= r_quot[31:0];
            end
        end
    end

    // sqrt step counter wraps at zero: done after the bit-0 step
    logic r_sq_last;
    always_ff @(posedge i_clk) begin
        if (i_cmd.sqrt_init) r_sq_last <= 1'b0;
        else if (i_cmd.sqrt_step && r_sqcnt == 6'd0) r_sq_last <= 1'b1;
    end

    // match check on registered read data
    logic match;
    always_comb begin
        logic [32:0] d;
        logic [32:0] m;
        match = (r_tol != '0);
        for (int k = 0; k < 8; k++) begin
            d = {rd[k][31], rd[k]} - {r_v[k][31], r_v[k]};
            m = d[32] ? (33'd0 - d) : d;
            if (m >= {16'd0, r_tol}) match = 1'b0;
        end
    end

    logic we;
    assign we = i_cmd.commit && !r_found && (r_vcnt < limit) && (r_ecnt < limit);

    generate
        for (genvar g = 0; g < 8; g++) begin : g_store
            vdi_ram #(.Width(32), .Depth(TableDepth)) u_ram (
                .i_clk   (i_clk),
                .i_we    (we),
                .i_waddr (r_vcnt[IdxW-1:0]),
                .i_wdata (r_v[g]),
                .i_raddr (r_scan[IdxW-1:0]),
                .o_rdata (rd[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcnt  <= '0;
            r_ecnt  <= '0;
            r_found <= 1'b0;
            r_scan  <= '0;
        end else begin
            if (i_cmd.load && i_new_mesh) begin
                r_vcnt <= '0;
                r_ecnt <= '0;
            end
            if (i_cmd.scan_clr) begin
                r_scan  <= '0;
                r_found <= 1'b0;
            end
            if (i_cmd.rd_issue) begin
                r_ridx <= r_scan[IdxW-1:0];
                r_scan <= r_scan + CntW'(1);
            end
            if (i_cmd.cmp_chk && !r_found && match) begin
                r_found <= 1'b1;
                r_hit   <= r_ridx;
            end
            if (i_cmd.commit) begin
                if (r_found) begin
                    if (r_ecnt < limit) begin
                        r_oidx <= r_hit;
                        r_oout <= OUT_MATCHED;
                        r_ecnt <= r_ecnt + CntW'(1);
                    end else begin
                        r_oidx <= '0;
                        r_oout <= OUT_DROPPED;
                    end
                end else if (we) begin
                    r_oidx <= r_vcnt[IdxW-1:0];
                    r_oout <= OUT_APPENDED;
                    r_vcnt <= r_vcnt + CntW'(1);
                    r_ecnt <= r_ecnt + CntW'(1);
                end else begin
                    r_oidx <= '0;
                    r_oout <= OUT_DROPPED;
                end
            end
        end
    end

    assign o_sts.scan_done = (r_scan >= r_vcnt);
    assign o_sts.found     = r_found || (i_cmd.cmp_chk && match);
    assign o_sts.sqrt_done = r_sq_last;
    assign o_sts.div_done  = (r_dcnt == 6'd0);

    assign o_vertex_index = r_oidx;
    assign o_outcome      = r_oout;
    assign o_unique_count = r_vcnt;
    assign o_index_count  = r_ecnt;
endmodule

@@ hdl/vertex_dedup_indexer_unit.sv @@
// Top level: vertex dedup indexer.
// One transaction at a time: a new one is accepted only after the previous result
// leaves, which an output stall on i_stall can hold back. Transaction time is set by the
// bit-serial square root, the restoring divider (one quotient bit a cycle per normal
// component) and the one-entry-a-cycle table read port, which searches the stored vertices.
// Synchronous active-low reset clears counts, sets capacity 1024, tolerance 1.
module vertex_dedup_indexer_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_new_mesh,
    input  logic [31:0]                  i_pos_x,
    input  logic [31:0]                  i_pos_y,
    input  logic [31:0]                  i_pos_z,
    input  logic [31:0]                  i_norm_x,
    input  logic [31:0]                  i_norm_y,
    input  logic [31:0]                  i_norm_z,
    input  logic [31:0]                  i_tex_u,
    input  logic [31:0]                  i_tex_v,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [vdi_pkg::IdxW-1:0]     o_vertex_index,
    output logic [1:0]                   o_outcome,
    output logic [vdi_pkg::CntW-1:0]     o_unique_count,
    output logic [vdi_pkg::CntW-1:0]     o_index_count,
    input  logic                         i_cfg_we,
    input  logic [vdi_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [vdi_pkg::CfgW-1:0]     i_cfg_data
);
    import vdi_pkg::*;

    t_cmd cmd;
    t_sts sts;

    vdi_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    vdi_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_new_mesh     (i_new_mesh),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_pos_z        (i_pos_z),
        .i_norm_x       (i_norm_x),
        .i_norm_y       (i_norm_y),
        .i_norm_z       (i_norm_z),
        .i_tex_u        (i_tex_u),
        .i_tex_v        (i_tex_v),
        .o_vertex_index (o_vertex_index),
        .o_outcome      (o_outcome),
        .o_unique_count (o_unique_count),
        .o_index_count  (o_index_count)
    );
endmodule

@@ hdl/vdi_checker.sv @@
// Port-level checker for the vertex dedup indexer, bound to the top level.
`include "vertex_dedup_indexer_unit_macros.svh"
module vdi_checker (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_valid,
    input logic                     o_stall,
    input logic                     o_valid,
    input logic                     i_stall,
    input logic [vdi_pkg::IdxW-1:0] o_vertex_index,
    input logic [1:0]               o_outcome,
    input logic [vdi_pkg::CntW-1:0] o_unique_count,
    input logic [vdi_pkg::CntW-1:0] o_index_count
);
    import vdi_pkg::*;

    `VDI_ASSERT_IMPL(a_no_overlap, i_clk, i_rst_n, o_valid, o_stall, "result while accepting")
    `VDI_ASSERT_IMPL(a_outcome_code, i_clk, i_rst_n, o_valid, o_outcome != 2'd3, "bad outcome")
    `VDI_ASSERT_IMPL(a_drop_zero, i_clk, i_rst_n, o_valid && o_outcome == OUT_DROPPED, o_vertex_index == '0, "drop index")
    `VDI_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_vertex_index), "output moved")
    `VDI_ASSERT_IMPL(a_count_order, i_clk, i_rst_n, o_valid, o_unique_count <= o_index_count, "counts")
endmodule

bind vertex_dedup_indexer_unit vdi_checker u_vdi_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_vertex_index (o_vertex_index),
    .o_outcome      (o_outcome),
    .o_unique_count (o_unique_count),
    .o_index_count  (o_index_count)
);
